### src/mvn_pkg.sv
// Shared types and constants for the mesh vertex normals unit.
package mvn_pkg;
	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_TRI   = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_RSVD  = 2'd3
	} req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TRD_A,
		ST_TRD_B,
		ST_TRD_C,
		ST_TCAP_C,
		ST_MUL,
		ST_MULW,
		ST_ACC_RD,
		ST_ACC_X,
		ST_ACC_Y,
		ST_ACC_Z,
		ST_ACC_WR,
		ST_Q_RD,
		ST_Q_CAP,
		ST_Q_NORM,
		ST_Q_SQ,
		ST_Q_SQW,
		ST_Q_SQRT,
		ST_Q_DIV,
		ST_Q_OUT
	} state_t;

	localparam int MAX_VERTICES = 1024;
	localparam int COORD_WIDTH  = 16;
	localparam int IN_BYTES  = 11;
	localparam int OUT_BYTES = 8;
endpackage

### src/mesh_vertex_normals_unit.sv
// Mesh vertex normals unit: sums triangle face normals per vertex and normalizes them on query.
//
// Word kinds on the input stream, set by tuser: a load stores a vertex position and clears
// its normal sum, so loads can follow back to back; a triangle reads its three corners from
// the position memory, forms the face cross product on one shared multiplier (six products),
// then runs a read-modify-write of the sum memory for each distinct corner; a query reads one
// sum, scales it by a one-bit-per-cycle shifter, squares its components on a separate
// multiplier, takes a square root one result bit per cycle and three bit-serial divides, or
// goes straight to the output for a zero sum. One word is worked on at a time; the input is
// held off while a result waits in the output register for m_tready. After reset a clearing
// pass writes the sum memory once per entry before tready rises.
module mesh_vertex_normals_unit #(
	parameter int SUM_WIDTH    = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// vertex_index[9:0], pos_x[25:10], pos_y[41:26], pos_z[57:42], corner_a[67:58],
	// corner_b[77:68], corner_c[87:78]
	input  logic [mvn_pkg::IN_BYTES*8-1:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_vertex[9:0], norm_x[25:10], norm_y[41:26], norm_z[57:42], zero fill
	output logic [mvn_pkg::OUT_BYTES*8-1:0] m_tdata,
	// zero_normal[0], sum_saturated[1]
	output logic [1:0]  m_tuser
);
	import mvn_pkg::*;

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * CW + 4;
	localparam int SW = SUM_WIDTH;
	localparam int MW = SW + 1;
	localparam int CNTW = 7;

	logic [CW-1:0] pos_mem_x [MAX_VERTICES];
	logic [CW-1:0] pos_mem_y [MAX_VERTICES];
	logic [CW-1:0] pos_mem_z [MAX_VERTICES];
	logic [3*SW:0] sum_mem [MAX_VERTICES];

	state_t state_q, state_d;
	logic [AW:0] clr_q;
	logic clearing;
	assign clearing = ~clr_q[AW];

	logic [9:0] vidx_q, ca_q, cb_q, cc_q;
	logic [CW-1:0] px_q, py_q, pz_q;
	logic signed [CW:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
	logic signed [CW-1:0] ax_q, ay_q, az_q;
	logic signed [CW-1:0] rx, ry, rz;
	logic signed [PW-1:0] nx_q, ny_q, nz_q, prod_q;
	logic [2:0] k_q;
	logic [1:0] corner_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] raddr;
	logic ren;
	logic [3*SW:0] rdata_q;
	logic signed [SW-1:0] sx_q, sy_q, sz_q;
	logic sat_q;
	logic [MW-1:0] tx_q, ty_q, tz_q;
	logic neg_x_q, neg_y_q, neg_z_q;
	logic [63:0] sq_q, rem_q;
	logic [63:0] r_q;
	logic [CNTW-1:0] cnt_q;
	logic [47:0] num_q;
	logic [32:0] drem_q;
	logic [15:0] quo_q [3];
	logic qvalid_q;

	logic [OUT_BYTES*8-1:0] out_data_q;
	logic [1:0] out_user_q;
	logic out_valid_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

	logic in_acc;
	assign s_tready = (state_q == ST_IDLE) && !clearing && !(out_valid_q && !m_tready);
	assign in_acc = s_tvalid && s_tready;

	logic [9:0] in_vi, in_a, in_b, in_c;
	assign in_vi = s_tdata[9:0];
	assign in_a = s_tdata[67:58];
	assign in_b = s_tdata[77:68];
	assign in_c = s_tdata[87:78];

	function automatic logic in_range(input logic [9:0] i);
		return 32'(i) < MAX_VERTICES;
	endfunction

	function automatic logic [15:0] fix(input logic [15:0] q, input logic neg);
		if (neg)
			return 16'(17'd0 - 17'(q));
		return (q > 16'd32767) ? 16'd32767 : q;
	endfunction

	// position memory: writes on load, registered reads
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == REQ_LOAD && in_range(in_vi)) begin
			pos_mem_x[in_vi[AW-1:0]] <= s_tdata[10 +: CW];
			pos_mem_y[in_vi[AW-1:0]] <= s_tdata[26 +: CW];
			pos_mem_z[in_vi[AW-1:0]] <= s_tdata[42 +: CW];
		end
		px_q <= pos_mem_x[raddr];
		py_q <= pos_mem_y[raddr];
		pz_q <= pos_mem_z[raddr];
	end
	assign rx = px_q;
	assign ry = py_q;
	assign rz = pz_q;

	always_comb begin
		unique case (state_q)
			ST_TRD_A: raddr = ca_q[AW-1:0];
			ST_TRD_B: raddr = cb_q[AW-1:0];
			ST_TRD_C: raddr = cc_q[AW-1:0];
			default:  raddr = addr_q;
		endcase
	end

	// sum memory
	logic swe;
	logic [AW-1:0] swaddr;
	logic [3*SW:0] swdata;
	always_ff @(posedge clk) begin
		if (swe)
			sum_mem[swaddr] <= swdata;
		if (ren)
			rdata_q <= sum_mem[addr_q];
	end

	// saturating add
	function automatic logic signed [SW:0] sat_add(input logic signed [SW-1:0] s,
			input logic signed [PW-1:0] v);
		logic signed [SW+1:0] t;
		logic signed [SW+1:0] mx;
		logic signed [SW+1:0] mn;
		logic ov;
		t = (SW+2)'(s) + (SW+2)'(v);
		mx = (SW+2)'({1'b0, {(SW-1){1'b1}}});
		mn = -mx - (SW+2)'(1);
		ov = (t > mx) || (t < mn);
		if (t > mx)
			return {1'b1, mx[SW-1:0]};
		else if (t < mn)
			return {1'b1, mn[SW-1:0]};
		return {ov, t[SW-1:0]};
	endfunction

	logic signed [SW:0] add_res;
	always_comb begin
		unique case (state_q)
			ST_ACC_Y: add_res = sat_add(sx_q, nx_q);
			ST_ACC_Z: add_res = sat_add(sy_q, ny_q);
			default:  add_res = sat_add(sz_q, nz_q);
		endcase
	end

	// next distinct corner
	logic tri_more;
	always_comb begin
		unique case (corner_q)
			2'd0: tri_more = (cb_q != ca_q) || (cc_q != ca_q);
			2'd1: tri_more = (cc_q != ca_q) && (cc_q != cb_q);
			default: tri_more = 1'b0;
		endcase
	end

	// shared multiplier
	logic signed [PW-1:0] ma, mb;
	logic [31:0] sqa;
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (k_q)
			3'd0: begin ma = PW'(uy_q); mb = PW'(vz_q); end
			3'd1: begin ma = PW'(uz_q); mb = PW'(vy_q); end
			3'd2: begin ma = PW'(uz_q); mb = PW'(vx_q); end
			3'd3: begin ma = PW'(ux_q); mb = PW'(vz_q); end
			3'd4: begin ma = PW'(ux_q); mb = PW'(vy_q); end
			default: begin ma = PW'(uy_q); mb = PW'(vx_q); end
		endcase
		unique case (k_q)
			3'd0: sqa = tx_q[31:0];
			3'd1: sqa = ty_q[31:0];
			default: sqa = tz_q[31:0];
		endcase
	end

	logic [MW-1:0] mmax;
	always_comb begin
		mmax = tx_q;
		if (ty_q > mmax) mmax = ty_q;
		if (tz_q > mmax) mmax = tz_q;
	end

	function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] s);
		logic signed [MW-1:0] e;
		e = MW'(s);
		return e[MW-1] ? MW'(-e) : MW'(e);
	endfunction

	// square root step
	logic [63:0] sq_try;
	logic [63:0] sq_bit;
	assign sq_bit = 64'd1 << {cnt_q[4:0], 1'b0};
	assign sq_try = r_q + sq_bit;

	logic [32:0] dsh;
	assign dsh = {drem_q[31:0], num_q[47]};

	always_comb begin
		state_d = state_q;
		ren = 1'b0;
		swe = 1'b0;
		swaddr = addr_q;
		swdata = '0;
		if (clearing) begin
			swe = 1'b1;
			swaddr = clr_q[AW-1:0];
		end
		unique case (state_q)
			ST_IDLE: if (in_acc) begin
				priority case (s_tuser)
					REQ_LOAD: if (in_range(in_vi)) begin
						swe = 1'b1;
						swaddr = in_vi[AW-1:0];
					end
					REQ_TRI: if (in_range(in_a) && in_range(in_b) && in_range(in_c))
						state_d = ST_TRD_A;
					REQ_QUERY: state_d = ST_Q_RD;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_TRD_A: state_d = ST_TRD_B;
			ST_TRD_B: state_d = ST_TRD_C;
			ST_TRD_C: state_d = ST_TCAP_C;
			ST_TCAP_C: state_d = ST_MUL;
			ST_MUL: state_d = ST_MULW;
			ST_MULW: state_d = (k_q == 3'd5) ? ST_ACC_RD : ST_MUL;
			ST_ACC_RD: begin
				ren = 1'b1;
				state_d = ST_ACC_X;
			end
			ST_ACC_X: state_d = ST_ACC_Y;
			ST_ACC_Y: state_d = ST_ACC_Z;
			ST_ACC_Z: state_d = ST_ACC_WR;
			ST_ACC_WR: begin
				swe = 1'b1;
				swdata = {sat_q | add_res[SW], add_res[SW-1:0], sy_q, sx_q};
				state_d = tri_more ? ST_ACC_RD : ST_IDLE;
			end
			ST_Q_RD: begin
				ren = 1'b1;
				state_d = ST_Q_CAP;
			end
			ST_Q_CAP: state_d = ST_Q_NORM;
			ST_Q_NORM:
				if (mmax == '0)
					state_d = ST_Q_OUT;
				else if (mmax >= (MW'(1) << 31) || mmax < (MW'(1) << 30))
					state_d = ST_Q_NORM;
				else
					state_d = ST_Q_SQ;
			ST_Q_SQ: state_d = ST_Q_SQW;
			ST_Q_SQW: state_d = (k_q == 3'd2) ? ST_Q_SQRT : ST_Q_SQ;
			ST_Q_SQRT: if (cnt_q == '0) state_d = ST_Q_DIV;
			ST_Q_DIV: if (cnt_q == '0 && k_q == 3'd2) state_d = ST_Q_OUT;
			ST_Q_OUT: if (!(out_valid_q && !m_tready)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing)
				clr_q <= clr_q + 1'b1;
			if (state_q == ST_Q_OUT && !(out_valid_q && !m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_acc) begin
				vidx_q <= in_vi;
				ca_q <= in_a;
				cb_q <= in_b;
				cc_q <= in_c;
				addr_q <= in_vi[AW-1:0];
				qvalid_q <= in_range(in_vi);
			end
			ST_TRD_B: begin
				ax_q <= rx;
				ay_q <= ry;
				az_q <= rz;
			end
			ST_TRD_C: begin
				ux_q <= (CW+1)'(rx) - (CW+1)'(ax_q);
				uy_q <= (CW+1)'(ry) - (CW+1)'(ay_q);
				uz_q <= (CW+1)'(rz) - (CW+1)'(az_q);
			end
			ST_TCAP_C: begin
				vx_q <= (CW+1)'(rx) - (CW+1)'(ax_q);
				vy_q <= (CW+1)'(ry) - (CW+1)'(ay_q);
				vz_q <= (CW+1)'(rz) - (CW+1)'(az_q);
				k_q <= 3'd0;
			end
			ST_MUL: prod_q <= ma * mb;
			ST_MULW: begin
				unique case (k_q)
					3'd0: nx_q <= prod_q;
					3'd1: nx_q <= nx_q - prod_q;
					3'd2: ny_q <= prod_q;
					3'd3: ny_q <= ny_q - prod_q;
					3'd4: nz_q <= prod_q;
					default: nz_q <= nz_q - prod_q;
				endcase
				k_q <= k_q + 3'd1;
				corner_q <= 2'd0;
				addr_q <= ca_q[AW-1:0];
			end
			ST_ACC_X: begin
				sx_q <= rdata_q[SW-1:0];
				sy_q <= rdata_q[2*SW-1:SW];
				sz_q <= rdata_q[3*SW-1:2*SW];
				sat_q <= rdata_q[3*SW];
			end
			ST_ACC_Y: begin
				sx_q <= add_res[SW-1:0];
				sat_q <= sat_q | add_res[SW];
			end
			ST_ACC_Z: begin
				sy_q <= add_res[SW-1:0];
				sat_q <= sat_q | add_res[SW];
			end
			ST_ACC_WR: begin
				priority if (corner_q == 2'd0) begin
					if (cb_q != ca_q) begin
						corner_q <= 2'd1;
						addr_q <= cb_q[AW-1:0];
					end else if (cc_q != ca_q) begin
						corner_q <= 2'd2;
						addr_q <= cc_q[AW-1:0];
					end else
						corner_q <= 2'd2;
				end else if (corner_q == 2'd1) begin
					corner_q <= (cc_q != ca_q && cc_q != cb_q) ? 2'd2 : 2'd3;
					addr_q <= cc_q[AW-1:0];
				end else
					corner_q <= 2'd3;
			end
			ST_Q_CAP: begin
				sx_q <= qvalid_q ? rdata_q[SW-1:0] : '0;
				sy_q <= qvalid_q ? rdata_q[2*SW-1:SW] : '0;
				sz_q <= qvalid_q ? rdata_q[3*SW-1:2*SW] : '0;
				sat_q <= qvalid_q & rdata_q[3*SW];
				tx_q <= qvalid_q ? mag(rdata_q[SW-1:0]) : '0;
				ty_q <= qvalid_q ? mag(rdata_q[2*SW-1:SW]) : '0;
				tz_q <= qvalid_q ? mag(rdata_q[3*SW-1:2*SW]) : '0;
			end
			ST_Q_NORM: begin
				neg_x_q <= sx_q[SW-1];
				neg_y_q <= sy_q[SW-1];
				neg_z_q <= sz_q[SW-1];
				if (mmax >= (MW'(1) << 31)) begin
					tx_q <= tx_q >> 1;
					ty_q <= ty_q >> 1;
					tz_q <= tz_q >> 1;
				end else if (mmax < (MW'(1) << 30)) begin
					tx_q <= tx_q << 1;
					ty_q <= ty_q << 1;
					tz_q <= tz_q << 1;
				end
				k_q <= 3'd0;
				sq_q <= '0;
				quo_q[0] <= '0;
				quo_q[1] <= '0;
				quo_q[2] <= '0;
			end
			ST_Q_SQ: rem_q <= 64'(sqa) * 64'(sqa);
			ST_Q_SQW: begin
				sq_q <= sq_q + rem_q;
				k_q <= (k_q == 3'd2) ? 3'd0 : k_q + 3'd1;
				r_q <= '0;
				cnt_q <= CNTW'(31);
			end
			ST_Q_SQRT: begin
				if (k_q == 3'd0) begin
					rem_q <= sq_q;
					k_q <= 3'd7;
				end else begin
					if (rem_q >= sq_try) begin
						rem_q <= rem_q - sq_try;
						r_q <= (r_q >> 1) + sq_bit;
					end else
						r_q <= r_q >> 1;
					if (cnt_q == '0) begin
						k_q <= 3'd0;
						cnt_q <= CNTW'(48);
					end else
						cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_Q_DIV: begin
				if (cnt_q == CNTW'(48)) begin
					unique case (k_q)
						3'd0: num_q <= {tx_q[31:0], 15'd0, 1'b0} + {16'd0, r_q[31:1], 1'b0} >> 1;
						3'd1: num_q <= ({ty_q[31:0], 15'd0, 1'b0} + {16'd0, r_q[31:1], 1'b0}) >> 1;
						default: num_q <= ({tz_q[31:0], 15'd0, 1'b0} + {16'd0, r_q[31:1], 1'b0})
							>> 1;
					endcase
					drem_q <= '0;
					cnt_q <= CNTW'(47);
				end else begin
					num_q <= {num_q[46:0], (dsh >= {1'b0, r_q[31:0]})};
					drem_q <= (dsh >= {1'b0, r_q[31:0]}) ? dsh - {1'b0, r_q[31:0]} : dsh;
					if (cnt_q == '0) begin
						quo_q[k_q[1:0]] <= ({num_q[46:0], (dsh >= {1'b0, r_q[31:0]})} > 48'd32768)
							? 16'd32768 : 16'({num_q[46:0], (dsh >= {1'b0, r_q[31:0]})});
						if (k_q != 3'd2) begin
							k_q <= k_q + 3'd1;
							cnt_q <= CNTW'(48);
						end
					end else
						cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_Q_OUT: if (!(out_valid_q && !m_tready)) begin
				out_data_q <= {6'd0, fix(quo_q[2], neg_z_q), fix(quo_q[1], neg_y_q),
					fix(quo_q[0], neg_x_q), vidx_q};
				out_user_q <= {sat_q, (tx_q == '0 && ty_q == '0 && tz_q == '0)};
			end
			default: ;
		endcase
	end
endmodule
